@@ rtl/dri_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dri_pkg: shared types and constants for the dead reckoning integrator
// Angle constants, register indexes, saturation and arctangent helpers.
// ----------------------------------------------------------------------------
package dri_pkg;

  // register indexes on the configuration port
  localparam int unsigned CFG_ADDR_W = 2;
  localparam logic [CFG_ADDR_W-1:0] REG_TIME_STEP = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_START_X   = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_START_Y   = 2'd2;

  localparam logic [15:0]        TIME_STEP_RST = 16'd1092;
  localparam logic signed [31:0] START_RST     = 32'sd25600;

  // angles in Q.32 radians
  localparam logic signed [35:0] PI_Q32      = 36'sd13493037705;
  localparam logic signed [35:0] TWO_PI_Q32  = 36'sd26986075409;
  localparam logic signed [35:0] HALF_PI_Q32 = 36'sd6746518852;
  localparam logic [33:0]        QUARTER_PI_Q32 = 34'd3373259426;

  // modulo 2pi reduction: restoring compare/subtract from 2pi*2^12 down to 2pi
  localparam int unsigned RED_CNT_W = 4;
  localparam logic [RED_CNT_W-1:0] RED_LAST_SHIFT = 4'd12;
  localparam logic [47:0] MOD_Q32   = 48'd26986075409;
  localparam logic [47:0] MOD_START = MOD_Q32 << RED_LAST_SHIFT;

  localparam logic signed [31:0] CORDIC_GAIN_Q30 = 32'sd652032874;

  localparam logic signed [31:0] S32_MAX = 32'sh7fffffff;
  localparam logic signed [31:0] S32_MIN = 32'sh80000000;

  // clamp a 35-bit signed sum into 32 bits
  function automatic logic signed [31:0] sat32(input logic signed [34:0] v);
    logic signed [31:0] res;
    if (v > 35'(S32_MAX)) begin
      res = S32_MAX;
    end else if (v < 35'(S32_MIN)) begin
      res = S32_MIN;
    end else begin
      res = v[31:0];
    end
    return res;
  endfunction

  // arctangent of 2^-idx in Q.32: odd power series in Q.60, rounded.
  // Elaboration-time only; divisions are done as long division.
  function automatic logic [33:0] atan_q32(input int unsigned idx);
    longint     sum;
    longint     e;
    logic [63:0] num;
    logic [63:0] quo;
    logic [63:0] rmd;
    logic [63:0] dvs;
    logic [33:0] res;
    sum = 0;
    if (idx == 0) begin
      res = QUARTER_PI_Q32;
    end else begin
      for (int k = 0; k < 64; k++) begin
        e = 60 - longint'(2 * k + 1) * longint'(idx);
        if (e >= 0) begin
          num = 64'd1 << e;
          dvs = 64'(2 * k + 1);
          quo = '0;
          rmd = '0;
          for (int b = 63; b >= 0; b--) begin
            rmd = {rmd[62:0], num[b]};
            if (rmd >= dvs) begin
              rmd    = rmd - dvs;
              quo[b] = 1'b1;
            end
          end
          if ((k % 2) == 1) begin
            sum = sum - longint'(quo);
          end else begin
            sum = sum + longint'(quo);
          end
        end
      end
      res = 34'((sum + (longint'(1) << 27)) >>> 28);
    end
    return res;
  endfunction

endpackage
`default_nettype wire

@@ rtl/dead_reckoning_integrator_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dead_reckoning_integrator_unit: odometry dead reckoning integrator
// Integrates speed and turn rate samples into x, y and heading sums using a
// sequenced CORDIC and one shared multiplier; reports sample 3, then every second.
// ----------------------------------------------------------------------------
// Channel   Dir  Handshake           Payload
// in_*      in   in_tvalid/tready    linear_speed, angular_rate
// out_*     out  out_tvalid/tready   est_x, est_y, est_heading
// cfg_*     in   cfg_wr_en           time_step, start_x, start_y
//
// Each sample steps through accept, the modulo 2pi reduction, wrap/fold,
// CORDIC_STEPS rotations, the five products through the single multiplier
// and the report. in_tready is high only in idle. A pending result sits in
// the output register; the next sample is taken meanwhile and only the
// report cycle waits if the old result is still unclaimed.
// Reset (rst_n low, synchronous) clears the sums and the sample phase and
// loads the register defaults.
// ----------------------------------------------------------------------------
module dead_reckoning_integrator_unit
  import dri_pkg::*;
#(
  parameter int unsigned CORDIC_STEPS = 16
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // input stream
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire logic [47:0]           in_tdata,   // [23:0] linear_speed, [47:24] angular_rate
  // result stream
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  output logic [95:0]                out_tdata,  // [31:0] est_x, [63:32] est_y,
                                                 // [95:64] est_heading
  // configuration writes
  input  wire logic                  cfg_wr_en,
  input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
  input  wire logic [31:0]           cfg_wr_data
);

  localparam int unsigned IW = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;
  localparam logic [IW-1:0] ITER_LAST = IW'(CORDIC_STEPS - 1);

  typedef enum logic [3:0] {
    S_IDLE, S_RED, S_WRAP0, S_WRAP1, S_FOLD, S_ROT, S_MUL, S_RND, S_ACC, S_OUT
  } state_t;

  // which sum the multiply chain is feeding
  typedef enum logic [1:0] {AX_X, AX_Y, AX_H} axis_t;

  // arctangent lookup, constant per iteration
  logic signed [35:0] atan_lut [CORDIC_STEPS];
  for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_atan
    assign atan_lut[g] = $signed({2'b00, atan_q32(g)});
  end

  state_t              state_r, state_nxt;
  axis_t               ax_r, ax_nxt;
  logic                pass_r, pass_nxt;   // 0: trig*speed, 1: (t or rate)*time_step

  // configuration
  logic [15:0]         ts_r, ts_nxt;
  logic signed [31:0]  sx_r, sx_nxt;
  logic signed [31:0]  sy_r, sy_nxt;

  // sample
  logic signed [23:0]  speed_r, speed_nxt;
  logic signed [23:0]  rate_r, rate_nxt;

  // angle reduction
  logic [47:0]         rem_r, rem_nxt;
  logic [47:0]         div_r, div_nxt;
  logic [RED_CNT_W-1:0] red_cnt_r, red_cnt_nxt;
  logic                neg_r, neg_nxt;
  logic                flip_r, flip_nxt;
  logic signed [35:0]  ang_r, ang_nxt;

  // CORDIC
  logic signed [31:0]  cx_r, cx_nxt;
  logic signed [31:0]  cy_r, cy_nxt;
  logic [IW-1:0]       iter_r, iter_nxt;

  // multiplier chain
  logic signed [57:0]  mul_p_r, mul_p_nxt;
  logic signed [33:0]  t_r, t_nxt;

  // running sums
  logic signed [31:0]  pos_x_r, pos_x_nxt;
  logic signed [31:0]  pos_y_r, pos_y_nxt;
  logic signed [31:0]  head_r, head_nxt;
  logic [1:0]          phase_r, phase_nxt;

  // result register
  logic                out_vld_r, out_vld_nxt;
  logic signed [31:0]  out_x_r, out_x_nxt;
  logic signed [31:0]  out_y_r, out_y_nxt;
  logic signed [31:0]  out_h_r, out_h_nxt;

  // combinational helpers
  logic                in_fire;
  logic [32:0]         head_abs;
  logic signed [31:0]  xs, ys;
  logic signed [33:0]  trig;
  logic signed [33:0]  mul_a;
  logic signed [23:0]  mul_b;
  logic signed [57:0]  rnd22, rnd24, rnd16;
  logic signed [31:0]  acc_old;
  logic signed [31:0]  acc_new;
  logic [1:0]          phase_adv;
  logic                emit;
  logic                out_busy;

  assign in_tready  = (state_r == S_IDLE);
  assign in_fire    = in_tvalid && in_tready;
  assign out_tvalid = out_vld_r;
  assign out_tdata  = {out_h_r, out_y_r, out_x_r};
  assign out_busy   = out_vld_r && !out_tready;

  assign head_abs = head_r[31] ? (33'd0 - 33'(head_r)) : 33'(head_r);

  assign xs = cx_r >>> iter_r;
  assign ys = cy_r >>> iter_r;

  assign trig = (ax_r == AX_Y) ? (flip_r ? -34'(cy_r) : 34'(cy_r))
                               : (flip_r ? -34'(cx_r) : 34'(cx_r));

  // shared multiplier operands
  always_comb begin
    if (!pass_r) begin
      mul_a = trig;
      mul_b = speed_r;
    end else begin
      mul_a = (ax_r == AX_H) ? 34'(rate_r) : t_r;
      mul_b = $signed({8'd0, ts_r});
    end
  end

  // round half up, then arithmetic shift
  assign rnd22 = (mul_p_r + 58'sd2097152) >>> 22;
  assign rnd24 = (mul_p_r + 58'sd8388608) >>> 24;
  assign rnd16 = (mul_p_r + 58'sd32768) >>> 16;

  always_comb begin
    case (ax_r)
      AX_X:    acc_old = pos_x_r;
      AX_Y:    acc_old = pos_y_r;
      default: acc_old = head_r;
    endcase
  end
  assign acc_new = sat32(35'(acc_old) + 35'(t_r));

  assign phase_adv = (phase_r == 2'd3) ? 2'd2 : phase_r + 2'd1;
  assign emit      = (phase_adv == 2'd3);

  always_comb begin
    state_nxt   = state_r;
    ax_nxt      = ax_r;
    pass_nxt    = pass_r;
    ts_nxt      = ts_r;
    sx_nxt      = sx_r;
    sy_nxt      = sy_r;
    speed_nxt   = speed_r;
    rate_nxt    = rate_r;
    rem_nxt     = rem_r;
    div_nxt     = div_r;
    red_cnt_nxt = red_cnt_r;
    neg_nxt     = neg_r;
    flip_nxt    = flip_r;
    ang_nxt     = ang_r;
    cx_nxt      = cx_r;
    cy_nxt      = cy_r;
    iter_nxt    = iter_r;
    mul_p_nxt   = mul_p_r;
    t_nxt       = t_r;
    pos_x_nxt   = pos_x_r;
    pos_y_nxt   = pos_y_r;
    head_nxt    = head_r;
    phase_nxt   = phase_r;
    out_vld_nxt = out_vld_r && !out_tready;
    out_x_nxt   = out_x_r;
    out_y_nxt   = out_y_r;
    out_h_nxt   = out_h_r;

    if (cfg_wr_en) begin
      unique case (cfg_addr)
        REG_TIME_STEP: ts_nxt = cfg_wr_data[15:0];
        REG_START_X:   sx_nxt = cfg_wr_data;
        REG_START_Y:   sy_nxt = cfg_wr_data;
        default:       ;
      endcase
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          speed_nxt   = in_tdata[23:0];
          rate_nxt    = in_tdata[47:24];
          // |heading| scaled to Q.32
          rem_nxt     = {head_abs[31:0], 16'd0};
          neg_nxt     = head_r[31];
          div_nxt     = MOD_START;
          red_cnt_nxt = RED_LAST_SHIFT;
          state_nxt   = S_RED;
        end
      end
      S_RED: begin
        if (rem_r >= div_r) begin
          rem_nxt = rem_r - div_r;
        end
        div_nxt     = div_r >> 1;
        red_cnt_nxt = red_cnt_r - 1'b1;
        if (red_cnt_r == '0) begin
          state_nxt = S_WRAP0;
        end
      end
      S_WRAP0: begin
        // truncating modulo gives a negative remainder for negative headings
        if (neg_r && (rem_r != '0)) begin
          ang_nxt = TWO_PI_Q32 - $signed({1'b0, rem_r[34:0]});
        end else begin
          ang_nxt = $signed({1'b0, rem_r[34:0]});
        end
        state_nxt = S_WRAP1;
      end
      S_WRAP1: begin
        if (ang_r > PI_Q32) begin
          ang_nxt = ang_r - TWO_PI_Q32;
        end
        state_nxt = S_FOLD;
      end
      S_FOLD: begin
        flip_nxt = 1'b0;
        if (ang_r > HALF_PI_Q32) begin
          ang_nxt  = ang_r - PI_Q32;
          flip_nxt = 1'b1;
        end else if (ang_r < -HALF_PI_Q32) begin
          ang_nxt  = ang_r + PI_Q32;
          flip_nxt = 1'b1;
        end
        cx_nxt    = CORDIC_GAIN_Q30;
        cy_nxt    = '0;
        iter_nxt  = '0;
        state_nxt = S_ROT;
      end
      S_ROT: begin
        if (ang_r >= 0) begin
          cx_nxt  = cx_r - ys;
          cy_nxt  = cy_r + xs;
          ang_nxt = ang_r - atan_lut[iter_r];
        end else begin
          cx_nxt  = cx_r + ys;
          cy_nxt  = cy_r - xs;
          ang_nxt = ang_r + atan_lut[iter_r];
        end
        iter_nxt = iter_r + 1'b1;
        if (iter_r == ITER_LAST) begin
          ax_nxt    = AX_X;
          pass_nxt  = 1'b0;
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        mul_p_nxt = 58'(mul_a) * 58'(mul_b);
        state_nxt = S_RND;
      end
      S_RND: begin
        if (!pass_r) begin
          t_nxt     = rnd22[33:0];
          pass_nxt  = 1'b1;
          state_nxt = S_MUL;
        end else begin
          t_nxt     = (ax_r == AX_H) ? rnd16[33:0] : rnd24[33:0];
          state_nxt = S_ACC;
        end
      end
      S_ACC: begin
        unique case (ax_r)
          AX_X: begin
            pos_x_nxt = acc_new;
            ax_nxt    = AX_Y;
            pass_nxt  = 1'b0;
            state_nxt = S_MUL;
          end
          AX_Y: begin
            pos_y_nxt = acc_new;
            ax_nxt    = AX_H;
            pass_nxt  = 1'b1;   // heading needs only rate*time_step
            state_nxt = S_MUL;
          end
          default: begin
            head_nxt  = acc_new;
            state_nxt = S_OUT;
          end
        endcase
      end
      S_OUT: begin
        if (!(emit && out_busy)) begin
          phase_nxt = phase_adv;
          if (emit) begin
            out_vld_nxt = 1'b1;
            out_x_nxt   = sat32(35'(pos_x_r) + 35'(sx_r));
            out_y_nxt   = sat32(35'(pos_y_r) + 35'(sy_r));
            out_h_nxt   = head_r;
          end
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      ax_r      <= AX_X;
      pass_r    <= 1'b0;
      ts_r      <= TIME_STEP_RST;
      sx_r      <= START_RST;
      sy_r      <= START_RST;
      pos_x_r   <= '0;
      pos_y_r   <= '0;
      head_r    <= '0;
      phase_r   <= '0;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      ax_r      <= ax_nxt;
      pass_r    <= pass_nxt;
      ts_r      <= ts_nxt;
      sx_r      <= sx_nxt;
      sy_r      <= sy_nxt;
      pos_x_r   <= pos_x_nxt;
      pos_y_r   <= pos_y_nxt;
      head_r    <= head_nxt;
      phase_r   <= phase_nxt;
      out_vld_r <= out_vld_nxt;
    end
    speed_r   <= speed_nxt;
    rate_r    <= rate_nxt;
    rem_r     <= rem_nxt;
    div_r     <= div_nxt;
    red_cnt_r <= red_cnt_nxt;
    neg_r     <= neg_nxt;
    flip_r    <= flip_nxt;
    ang_r     <= ang_nxt;
    cx_r      <= cx_nxt;
    cy_r      <= cy_nxt;
    iter_r    <= iter_nxt;
    mul_p_r   <= mul_p_nxt;
    t_r       <= t_nxt;
    out_x_r   <= out_x_nxt;
    out_y_r   <= out_y_nxt;
    out_h_r   <= out_h_nxt;
  end

  // reduction must leave a remainder below 2pi
  a_red_done: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WRAP0) |-> (rem_r < MOD_Q32))
    else $error("angle reduction left remainder >= 2pi");

  // CORDIC residual angle stays within the folded half circle
  a_rot_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ROT) |-> ((ang_r <= HALF_PI_Q32) && (ang_r >= -HALF_PI_Q32)))
    else $error("CORDIC residual angle out of range");

  // a report is made only when the phase lands on 3
  a_emit_phase: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_OUT) && emit && !out_busy) |=> (phase_r == 2'd3) && out_vld_r)
    else $error("result issued at wrong sample phase");

  // one sample at a time: no new transaction right after an accept
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> !in_tready)
    else $error("input accepted while busy");

endmodule
`default_nettype wire
